### src/interrupt_controller_registers_defines.svh
// Assertion macros for the checker file of the interrupt controller register store.
`ifndef INTERRUPT_CONTROLLER_REGISTERS_DEFINES_SVH
`define INTERRUPT_CONTROLLER_REGISTERS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ICR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icr assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ICR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icr assertion failed");

`endif

### src/icr_pkg.sv
// Package with the types, codes and constants of the interrupt controller register store.
`timescale 1ns / 1ps

package icr_pkg;

    // Number of interrupt lines and the index width that addresses them.
    localparam int NUM_IRQ    = 128;
    localparam int IDX_W      = (NUM_IRQ > 1) ? $clog2(NUM_IRQ) : 1;

    // Priority encoding: four implemented level bits, grouping codes start at three.
    localparam int PRIO_BITS  = 4;
    localparam int GROUP_BASE = 3;

    // Stream widths, fields packed from the lowest bit up; the data widths are padded to bytes.
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 16;

    typedef enum logic [3:0] {
        MODE_ENABLE     = 4'd0,
        MODE_DISABLE    = 4'd1,
        MODE_SET_PEND   = 4'd2,
        MODE_CLEAR_PEND = 4'd3,
        MODE_SOFT_TRIG  = 4'd4,
        MODE_READ       = 4'd5,
        MODE_SET_PRIO   = 4'd6,
        MODE_ACTIVATE   = 4'd7,
        MODE_DEACTIVATE = 4'd8
    } mode_t;

    typedef logic [IDX_W-1:0] idx_t;

    // Everything stored for one interrupt line.
    typedef struct packed {
        logic       enabled;
        logic       pending;
        logic       active;
        logic [7:0] priority_byte;
    } entry_t;

    // One accepted operation.
    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] irq;
        logic [3:0] preempt_level;
        logic [3:0] sub_level;
        logic [2:0] group_code;
    } item_t;

    // One result.
    typedef struct packed {
        logic       error;
        entry_t     line;
        logic [2:0] grouping;
    } result_t;

    // Write request into the line store.
    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } wr_req_t;

    // Update strobes produced by the execute logic.
    typedef struct packed {
        logic entry_wr;
        logic grouping_wr;
    } exec_ctl_t;

endpackage

### src/icr_store.sv
// Line store: entry memory with reset-cleared valid bits and write-to-read forwarding.
`timescale 1ns / 1ps

module icr_store
    import icr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    rd_en,
    input  idx_t    rd_addr,
    input  wr_req_t wr,
    output entry_t  rd_entry
);

    entry_t               mem [NUM_IRQ];
    logic [NUM_IRQ-1:0]   valid_reg;
    entry_t               mem_rd_reg;
    logic                 vld_rd_reg;
    logic                 fwd_sel_reg;
    entry_t               fwd_data_reg;

    // Memory write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // A line that was never written since reset reads as all zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Capture the valid bit and, when the same line is written in this cycle, the new data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            vld_rd_reg   <= valid_reg[rd_addr] || (wr.en && (wr.addr == rd_addr));
            fwd_sel_reg  <= wr.en && (wr.addr == rd_addr);
            fwd_data_reg <= wr.data;
        end
    end

    // Resolve forwarding and the reset value.
    always_comb begin
        if (fwd_sel_reg) begin
            rd_entry = fwd_data_reg;
        end else if (vld_rd_reg) begin
            rd_entry = mem_rd_reg;
        end else begin
            rd_entry = '0;
        end
    end

endmodule

### src/icr_exec.sv
// Execute logic: applies one operation to the addressed line and forms the result.
`timescale 1ns / 1ps

module icr_exec
    import icr_pkg::*;
(
    input  item_t      item,
    input  entry_t     cur_entry,
    input  logic [2:0] grouping,
    output entry_t     new_entry,
    output exec_ctl_t  ctl,
    output result_t    result
);

    logic       in_range;
    logic [2:0] sub_bits;
    logic [2:0] pre_bits;
    logic       prio_ok;
    logic [3:0] level;
    logic       error;

    // Priority argument checks and level encoding.
    always_comb begin
        sub_bits = item.group_code - 3'(GROUP_BASE);
        pre_bits = 3'(PRIO_BITS) - sub_bits;
        prio_ok  = (item.group_code >= 3'(GROUP_BASE))
                   && ((item.sub_level >> sub_bits) == 4'd0)
                   && ((item.preempt_level >> pre_bits) == 4'd0);
        level    = (item.preempt_level << sub_bits) | item.sub_level;
    end

    assign in_range = (item.irq < 8'(NUM_IRQ));

    // Operation decode.
    always_comb begin
        new_entry = cur_entry;
        ctl       = '0;
        error     = 1'b0;
        if (!in_range) begin
            error = 1'b1;
        end else begin
            unique case (mode_t'(item.mode))
                MODE_ENABLE: begin
                    new_entry.enabled = 1'b1;
                    ctl.entry_wr      = 1'b1;
                end
                MODE_DISABLE: begin
                    new_entry.enabled = 1'b0;
                    ctl.entry_wr      = 1'b1;
                end
                MODE_SET_PEND, MODE_SOFT_TRIG: begin
                    new_entry.pending = 1'b1;
                    ctl.entry_wr      = 1'b1;
                end
                MODE_CLEAR_PEND: begin
                    new_entry.pending = 1'b0;
                    ctl.entry_wr      = 1'b1;
                end
                MODE_READ: begin
                    error = 1'b0;
                end
                MODE_SET_PRIO: begin
                    if (prio_ok) begin
                        new_entry.priority_byte = {level, 4'b0000};
                        ctl.entry_wr            = 1'b1;
                        ctl.grouping_wr         = 1'b1;
                    end else begin
                        error = 1'b1;
                    end
                end
                MODE_ACTIVATE: begin
                    new_entry.active = 1'b1;
                    ctl.entry_wr     = 1'b1;
                end
                MODE_DEACTIVATE: begin
                    new_entry.active = 1'b0;
                    ctl.entry_wr     = 1'b1;
                end
                default: begin
                    error = 1'b1;
                end
            endcase
        end
    end

    // Result shows the line after the operation, or zeros for a line out of range.
    always_comb begin
        result.error    = error;
        result.line     = in_range ? new_entry : '0;
        result.grouping = ctl.grouping_wr ? item.group_code : grouping;
    end

endmodule

### src/interrupt_controller_registers.sv
// An accepted transaction passes the input register and the master-side output register.
// Throughput: one transaction per cycle while results are taken; the store is read when a
// transaction is accepted and written back as the execute stage moves on, with forwarding
// between the two. Reset: aresetn, synchronous and active low, empties the pipeline and
// clears every line and the grouping field at once; there is no clearing pass.
`timescale 1ns / 1ps

module interrupt_controller_registers
    import icr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // irq[7:0], preempt_level[11:8], sub_level[15:12], group_code[18:16], zeros above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[3:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // error[0], enabled[1], pending[2], active[3], priority_byte[11:4], grouping[14:12], zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic       s_accept;
    logic       out_free;
    logic       st1_move;
    item_t      in_item;
    logic       st1_valid_reg;
    item_t      st1_item_reg;
    logic       m_valid_reg;
    result_t    m_data_reg;
    logic [2:0] grouping_reg;
    entry_t     cur_entry;
    entry_t     new_entry;
    exec_ctl_t  ctl;
    result_t    result;
    wr_req_t    wr;

    // Handshake: the execute stage moves when the output register is free.
    assign out_free = !m_valid_reg || m_tready;
    assign st1_move = st1_valid_reg && out_free;
    assign s_tready = !st1_valid_reg || st1_move;
    assign s_accept = s_tvalid && s_tready;

    // Unpack the input transaction.
    always_comb begin
        in_item.mode          = s_tuser[3:0];
        in_item.irq           = s_tdata[7:0];
        in_item.preempt_level = s_tdata[11:8];
        in_item.sub_level     = s_tdata[15:12];
        in_item.group_code    = s_tdata[18:16];
    end

    // Input register feeding the execute stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_item_reg <= in_item;
        end
    end

    // Write back of the line in the cycle the execute stage moves on.
    always_comb begin
        wr.en   = st1_move && ctl.entry_wr;
        wr.addr = st1_item_reg.irq[IDX_W-1:0];
        wr.data = new_entry;
    end

    icr_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (in_item.irq[IDX_W-1:0]),
        .wr       (wr),
        .rd_entry (cur_entry)
    );

    icr_exec u_exec (
        .item      (st1_item_reg),
        .cur_entry (cur_entry),
        .grouping  (grouping_reg),
        .new_entry (new_entry),
        .ctl       (ctl),
        .result    (result)
    );

    // Shared priority grouping field.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grouping_reg <= 3'd0;
        end else if (st1_move && ctl.grouping_wr) begin
            grouping_reg <= st1_item_reg.group_code;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_move) begin
            m_data_reg <= result;
        end
    end

    // Pack the result transaction.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg.grouping, m_data_reg.line.priority_byte,
                       m_data_reg.line.active, m_data_reg.line.pending,
                       m_data_reg.line.enabled, m_data_reg.error};

endmodule

### src/icr_port_checker.sv
// Port-level checker for the interrupt controller register store, bound to the top level.
`timescale 1ns / 1ps
`include "interrupt_controller_registers_defines.svh"

module icr_port_checker
    import icr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    `ICR_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ICR_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // The input side only stalls behind a result that is waiting to be taken.
    `ICR_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // A fresh result traces back to an accepted input transaction.
    `ICR_ASSERT_IMPL(a_result_src, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind interrupt_controller_registers icr_port_checker u_icr_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
